// File: hw/rtl/mmr_pkg.sv
package mmr_pkg;

    localparam int NUM_MODULES = 21;
    localparam int QUEUE_DEPTH = 15;

    localparam int BODY_WORDS = 7;
    localparam int WORD_W     = 32;
    localparam int ID_W       = 16;
    localparam int LEN_W      = 16;
    localparam int SRC_W      = 15;
    localparam int ENTRY_W    = LEN_W + BODY_WORDS * WORD_W;

    localparam int MEM_DEPTH = NUM_MODULES * QUEUE_DEPTH;
    localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int SLOT_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int MOD_W     = (NUM_MODULES > 1) ? $clog2(NUM_MODULES) : 1;

    localparam logic [ID_W-1:0]  IR_KEY_LEN = ID_W'(4);

    typedef enum logic [1:0] {
        OP_DELIVER = 2'd0,
        OP_READ    = 2'd1,
        OP_ARM     = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_BAD   = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_IR    = 2'd1,
        EV_TIMER = 2'd2,
        EV_READ  = 2'd3
    } event_t;

    localparam logic CFG_IR_SOURCE    = 1'b0;
    localparam logic CFG_POWER_SOURCE = 1'b1;

    typedef struct packed {
        logic [1:0]                       op;
        logic signed [ID_W-1:0]           module_id;
        logic signed [LEN_W-1:0]          msg_len;
        logic [BODY_WORDS-1:0][WORD_W-1:0] body;
    } item_t;

    typedef struct packed {
        logic              we;
        logic              re;
        logic [ADDR_W-1:0] addr;
    } mem_req_t;

    typedef struct packed {
        status_t                 status;
        event_t                  kind;
        logic signed [ID_W-1:0]  module_id;
        logic signed [LEN_W-1:0] len;
        logic [WORD_W-1:0]       w0;
        logic                    from_mem;
    } meta_t;

endpackage

// File: hw/rtl/mmr_ram.sv
module mmr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/mmr_dispatch.sv
module mmr_dispatch
    import mmr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  item_t            item,
    input  logic [SRC_W-1:0] ir_id,
    input  logic [SRC_W-1:0] pwr_id,
    output mem_req_t         req,
    output meta_t            meta
);

    logic [SLOT_W-1:0] wr_slot_reg [NUM_MODULES];
    logic [SLOT_W-1:0] rd_slot_reg [NUM_MODULES];
    logic [CNT_W-1:0]  cnt_reg     [NUM_MODULES];
    logic              armed_reg;

    logic              id_ok;
    logic [ID_W-1:0]   idx_full;
    logic [MOD_W-1:0]  m;
    logic              is_ir;
    logic              is_pwr;
    logic              push;
    logic              pop;
    logic              set_armed;
    logic              clr_armed;
    logic [ADDR_W-1:0] base;
    logic [SLOT_W-1:0] cur_wr;
    logic [SLOT_W-1:0] cur_rd;
    logic [CNT_W-1:0]  cur_cnt;

    always_comb
    begin
        id_ok    = !item.module_id[ID_W-1] && (item.module_id != '0)
                   && ($unsigned(item.module_id) <= ID_W'(NUM_MODULES));
        idx_full = $unsigned(item.module_id) - ID_W'(1);
        m        = idx_full[MOD_W-1:0];
        base     = ADDR_W'(m) * ADDR_W'(QUEUE_DEPTH);
        cur_wr   = id_ok ? wr_slot_reg[m] : '0;
        cur_rd   = id_ok ? rd_slot_reg[m] : '0;
        cur_cnt  = id_ok ? cnt_reg[m] : '0;

        // negative ids never match the unsigned source registers
        is_ir  = !item.module_id[ID_W-1] && (item.module_id[SRC_W-1:0] == ir_id)
                 && (item.msg_len == IR_KEY_LEN);
        is_pwr = !item.module_id[ID_W-1] && (item.module_id[SRC_W-1:0] == pwr_id)
                 && (item.msg_len == IR_KEY_LEN) && (item.body[0] == '0);

        req       = '0;
        meta      = '0;
        push      = 1'b0;
        pop       = 1'b0;
        set_armed = 1'b0;
        clr_armed = 1'b0;

        case (item.op)
            OP_DELIVER:
            begin
                meta.module_id = item.module_id;
                if (is_ir)
                begin
                    meta.kind = EV_IR;
                    meta.len  = item.msg_len;
                    meta.w0   = item.body[0];
                end
                else if (is_pwr)
                begin
                    if (armed_reg)
                    begin
                        meta.kind = EV_TIMER;
                        clr_armed = 1'b1;
                    end
                end
                else if (!id_ok)
                begin
                    meta.status = ST_BAD;
                end
                else if (cur_cnt >= CNT_W'(QUEUE_DEPTH))
                begin
                    meta.status = ST_FULL;
                end
                else
                begin
                    req.we   = 1'b1;
                    req.addr = base + ADDR_W'(cur_wr);
                    push     = 1'b1;
                end
            end
            OP_READ:
            begin
                meta.module_id = item.module_id;
                if (!id_ok)
                begin
                    meta.status = ST_BAD;
                end
                else if (cur_cnt == '0)
                begin
                    meta.status = ST_EMPTY;
                end
                else
                begin
                    meta.kind     = EV_READ;
                    meta.from_mem = 1'b1;
                    req.re        = 1'b1;
                    req.addr      = base + ADDR_W'(cur_rd);
                    pop           = 1'b1;
                end
            end
            OP_ARM:
            begin
                set_armed = 1'b1;
            end
            default:
            begin
            end
        endcase

        // state only moves when the transaction is actually taken
        req.we = req.we && fire;
        req.re = req.re && fire;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_MODULES; i++)
            begin
                wr_slot_reg[i] <= '0;
                rd_slot_reg[i] <= '0;
                cnt_reg[i]     <= '0;
            end
            armed_reg <= 1'b0;
        end
        else if (fire)
        begin
            if (push)
            begin
                wr_slot_reg[m] <= (cur_wr == SLOT_W'(QUEUE_DEPTH - 1)) ? '0 : cur_wr + 1'b1;
                cnt_reg[m]     <= cur_cnt + 1'b1;
            end
            if (pop)
            begin
                rd_slot_reg[m] <= (cur_rd == SLOT_W'(QUEUE_DEPTH - 1)) ? '0 : cur_rd + 1'b1;
                cnt_reg[m]     <= cur_cnt - 1'b1;
            end
            if (set_armed)
            begin
                armed_reg <= 1'b1;
            end
            else if (clr_armed)
            begin
                armed_reg <= 1'b0;
            end
        end
    end

endmodule

// File: hw/rtl/mailbox_message_router.sv
// channel   direction  handshake            payload
// in        input      in_valid / in_stall  op, module_id, msg_len, body_w0..body_w6
// out       output     out_valid / out_stall status, event_kind, out_module_id, out_len,
//                                           out_w0..out_w6
// cfg       input      cfg_we               cfg_index, cfg_data
//
// One transaction per cycle sustained while out_stall is low; a result becomes valid once
// the transaction moves on from the input register (input register loads at acceptance, result
// register and the message store's registered read load when the transaction moves on).
// rst_n clears queue pointers, fill counts and the wakeup flag, and returns the source ids
// to 3 and 5; message store contents are not cleared and need no clearing pass.
// out_stall holds the result register and the store read data; in_stall follows it
// once the input register is occupied.
module mailbox_message_router
    import mmr_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,

    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [1:0]               op,
    input  logic signed [ID_W-1:0]   module_id,
    input  logic signed [LEN_W-1:0]  msg_len,
    input  logic [WORD_W-1:0]        body_w0,
    input  logic [WORD_W-1:0]        body_w1,
    input  logic [WORD_W-1:0]        body_w2,
    input  logic [WORD_W-1:0]        body_w3,
    input  logic [WORD_W-1:0]        body_w4,
    input  logic [WORD_W-1:0]        body_w5,
    input  logic [WORD_W-1:0]        body_w6,

    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [1:0]               status,
    output logic [1:0]               event_kind,
    output logic signed [ID_W-1:0]   out_module_id,
    output logic signed [LEN_W-1:0]  out_len,
    output logic [WORD_W-1:0]        out_w0,
    output logic [WORD_W-1:0]        out_w1,
    output logic [WORD_W-1:0]        out_w2,
    output logic [WORD_W-1:0]        out_w3,
    output logic [WORD_W-1:0]        out_w4,
    output logic [WORD_W-1:0]        out_w5,
    output logic [WORD_W-1:0]        out_w6,

    input  logic                     cfg_we,
    input  logic                     cfg_index,
    input  logic [SRC_W-1:0]         cfg_data
);

    item_t            item_reg;
    logic             s1_valid_reg;
    logic             s1_valid_next;
    meta_t            meta_reg;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [SRC_W-1:0] ir_id_reg;
    logic [SRC_W-1:0] pwr_id_reg;

    logic             s2_ready;
    logic             fire;
    logic             accept;
    mem_req_t         req;
    meta_t            meta;
    logic [ENTRY_W-1:0] wr_entry;
    logic [ENTRY_W-1:0] rd_entry;
    logic [LEN_W-1:0]   rd_len;
    logic [BODY_WORDS-1:0][WORD_W-1:0] rd_body;

    assign s2_ready = !out_valid_reg || !out_stall;
    assign fire     = s1_valid_reg && s2_ready;
    assign in_stall = s1_valid_reg && !s2_ready;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next  = accept ? 1'b1 : (fire ? 1'b0 : s1_valid_reg);
        out_valid_next = fire ? 1'b1 : (out_stall ? out_valid_reg : 1'b0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            ir_id_reg     <= SRC_W'(3);
            pwr_id_reg    <= SRC_W'(5);
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_IR_SOURCE:    ir_id_reg  <= cfg_data;
                    CFG_POWER_SOURCE: pwr_id_reg <= cfg_data;
                    default:          ir_id_reg  <= ir_id_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.op        <= op;
            item_reg.module_id <= module_id;
            item_reg.msg_len   <= msg_len;
            item_reg.body      <= {body_w6, body_w5, body_w4, body_w3,
                                   body_w2, body_w1, body_w0};
        end
        if (fire)
        begin
            meta_reg <= meta;
        end
    end

    mmr_dispatch u_dispatch (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (item_reg),
        .ir_id  (ir_id_reg),
        .pwr_id (pwr_id_reg),
        .req    (req),
        .meta   (meta)
    );

    assign wr_entry = {item_reg.msg_len, item_reg.body};

    mmr_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MEM_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (req.we),
        .waddr (req.addr),
        .wdata (wr_entry),
        .re    (req.re),
        .raddr (req.addr),
        .rdata (rd_entry)
    );

    assign rd_len  = rd_entry[ENTRY_W-1 -: LEN_W];
    assign rd_body = rd_entry[BODY_WORDS*WORD_W-1:0];

    assign out_valid     = out_valid_reg;
    assign status        = meta_reg.status;
    assign event_kind    = meta_reg.kind;
    assign out_module_id = meta_reg.module_id;
    assign out_len       = meta_reg.from_mem ? $signed(rd_len) : meta_reg.len;
    assign out_w0        = meta_reg.from_mem ? rd_body[0] : meta_reg.w0;
    assign out_w1        = meta_reg.from_mem ? rd_body[1] : '0;
    assign out_w2        = meta_reg.from_mem ? rd_body[2] : '0;
    assign out_w3        = meta_reg.from_mem ? rd_body[3] : '0;
    assign out_w4        = meta_reg.from_mem ? rd_body[4] : '0;
    assign out_w5        = meta_reg.from_mem ? rd_body[5] : '0;
    assign out_w6        = meta_reg.from_mem ? rd_body[6] : '0;

endmodule

// File: verif/mailbox_message_router_tb.sv
module mailbox_message_router_tb;
    import mmr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_UNUSED     = 2'd3;
    localparam int         MAX_WAIT      = 13;
    localparam int         ITEMS_PER_RUN = 230;
    localparam int         NUM_PHASES    = 5;
    localparam int         MAX_REPORTS   = 10;

    typedef struct packed {
        status_t                           status;
        event_t                            kind;
        logic signed [ID_W-1:0]            module_id;
        logic signed [LEN_W-1:0]           len;
        logic [BODY_WORDS-1:0][WORD_W-1:0] body;
    } result_t;

    typedef struct packed {
        logic signed [LEN_W-1:0]           len;
        logic [BODY_WORDS-1:0][WORD_W-1:0] body;
    } entry_t;

    typedef struct {
        item_t   stim;
        bit      typed;
        result_t want;
    } vector_t;

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_stall;
    logic [1:0]              op;
    logic signed [ID_W-1:0]  module_id;
    logic signed [LEN_W-1:0] msg_len;
    logic [WORD_W-1:0]       body_w0, body_w1, body_w2, body_w3, body_w4, body_w5, body_w6;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic [1:0]              status;
    logic [1:0]              event_kind;
    logic signed [ID_W-1:0]  out_module_id;
    logic signed [LEN_W-1:0] out_len;
    logic [WORD_W-1:0]       out_w0, out_w1, out_w2, out_w3, out_w4, out_w5, out_w6;
    logic                    cfg_we;
    logic                    cfg_index;
    logic [SRC_W-1:0]        cfg_data;

    mailbox_message_router dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .op            (op),
        .module_id     (module_id),
        .msg_len       (msg_len),
        .body_w0       (body_w0),
        .body_w1       (body_w1),
        .body_w2       (body_w2),
        .body_w3       (body_w3),
        .body_w4       (body_w4),
        .body_w5       (body_w5),
        .body_w6       (body_w6),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .event_kind    (event_kind),
        .out_module_id (out_module_id),
        .out_len       (out_len),
        .out_w0        (out_w0),
        .out_w1        (out_w1),
        .out_w2        (out_w2),
        .out_w3        (out_w3),
        .out_w4        (out_w4),
        .out_w5        (out_w5),
        .out_w6        (out_w6),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // router mirror
    entry_t           msg_store [NUM_MODULES][QUEUE_DEPTH];
    int               wr_slot   [NUM_MODULES];
    int               rd_slot   [NUM_MODULES];
    int               fill      [NUM_MODULES];
    bit               wake_armed;
    logic [SRC_W-1:0] ir_src;
    logic [SRC_W-1:0] pwr_src;

    result_t expected_results[$];
    vector_t directed[$];

    int  mismatches;
    int  n_sent, n_checked;
    int  n_queued, n_read, n_full, n_ir, n_wake, n_bad, n_empty;
    int  stall_left;
    bit  send_fast, recv_fast;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #1ms;
        $display("mailbox_message_router_tb failed");
        $finish;
    end

    function automatic result_t route_message(item_t it);
        result_t r;
        int      m;
        int      s;
        r = '0;
        if (it.op == OP_UNUSED)
            return r;
        r.module_id = it.module_id;
        if (it.op == OP_ARM)
        begin
            wake_armed  = 1'b1;
            r.module_id = '0;
            return r;
        end
        m = (it.module_id >= 1 && it.module_id <= NUM_MODULES) ? int'(it.module_id) - 1 : -1;
        if (it.op == OP_DELIVER)
        begin
            // source ids are unsigned: a negative module id never matches
            if (!it.module_id[ID_W-1] && it.module_id[SRC_W-1:0] == ir_src && it.msg_len == 4)
            begin
                r.kind    = EV_IR;
                r.len     = it.msg_len;
                r.body[0] = it.body[0];
                n_ir++;
                return r;
            end
            if (!it.module_id[ID_W-1] && it.module_id[SRC_W-1:0] == pwr_src
                && it.msg_len == 4 && it.body[0] == '0)
            begin
                if (wake_armed)
                begin
                    wake_armed = 1'b0;
                    r.kind     = EV_TIMER;
                    n_wake++;
                end
                return r;
            end
            if (m < 0)
            begin
                r.status = ST_BAD;
                n_bad++;
            end
            else if (fill[m] >= QUEUE_DEPTH)
            begin
                r.status = ST_FULL;
                n_full++;
            end
            else
            begin
                s = wr_slot[m];
                msg_store[m][s] = '{it.msg_len, it.body};
                wr_slot[m] = (s + 1) % QUEUE_DEPTH;
                fill[m]++;
                n_queued++;
            end
            return r;
        end
        // read
        if (m < 0)
        begin
            r.status = ST_BAD;
            n_bad++;
        end
        else if (fill[m] == 0)
        begin
            r.status = ST_EMPTY;
            n_empty++;
        end
        else
        begin
            s = rd_slot[m];
            r.kind = EV_READ;
            r.len  = msg_store[m][s].len;
            r.body = msg_store[m][s].body;
            rd_slot[m] = (s + 1) % QUEUE_DEPTH;
            fill[m]--;
            n_read++;
        end
        return r;
    endfunction

    function automatic item_t stim(logic [1:0] o, logic signed [ID_W-1:0] id,
                                   logic signed [LEN_W-1:0] len, logic [WORD_W-1:0] w0,
                                   logic [WORD_W-1:0] rest);
        item_t it;
        it.op        = o;
        it.module_id = id;
        it.msg_len   = len;
        it.body[0]   = w0;
        for (int i = 1; i < BODY_WORDS; i++)
            it.body[i] = rest ^ WORD_W'(i);
        return it;
    endfunction

    function automatic result_t res(status_t st, event_t ev, logic signed [ID_W-1:0] id,
                                    logic signed [LEN_W-1:0] len, logic [WORD_W-1:0] w0);
        result_t r;
        r         = '0;
        r.status  = st;
        r.kind    = ev;
        r.module_id = id;
        r.len     = len;
        r.body[0] = w0;
        return r;
    endfunction

    function automatic logic signed [ID_W-1:0] pick_module_id();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return ID_W'($urandom_range(1, 3));
        if (r < 60)
            return ID_W'($urandom_range(1, NUM_MODULES));
        if (r < 70)
            return ID_W'(ir_src);
        if (r < 80)
            return ID_W'(pwr_src);
        if (r < 90)
        begin
            case ($urandom_range(0, 5))
                0: return '0;
                1: return ID_W'(NUM_MODULES + 1);
                2: return -1;
                3: return 16'sh7fff;
                4: return 16'sh8000;
                default: return {1'b1, pwr_src};
            endcase
        end
        return ID_W'($urandom);
    endfunction

    function automatic item_t random_item(int deliver_pct);
        item_t it;
        int    r;
        r = $urandom_range(0, 99);
        if (r < deliver_pct)
            it.op = OP_DELIVER;
        else if (r < 88)
            it.op = OP_READ;
        else if (r < 96)
            it.op = OP_ARM;
        else
            it.op = OP_UNUSED;
        it.module_id = pick_module_id();
        it.msg_len   = ($urandom_range(0, 99) < 40) ? LEN_W'(4) : LEN_W'($urandom);
        for (int i = 0; i < BODY_WORDS; i++)
            it.body[i] = $urandom;
        if ($urandom_range(0, 99) < 30)
            it.body[0] = '0;
        return it;
    endfunction

    task automatic send_item(input item_t it, input bit typed, input result_t want);
        int gap;
        result_t predicted;
        if (n_sent % 40 == 0)
            send_fast = ($urandom_range(0, 2) == 0);
        gap = send_fast ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        op        = it.op;
        module_id = it.module_id;
        msg_len   = it.msg_len;
        body_w0   = it.body[0];
        body_w1   = it.body[1];
        body_w2   = it.body[2];
        body_w3   = it.body[3];
        body_w4   = it.body[4];
        body_w5   = it.body[5];
        body_w6   = it.body[6];
        in_valid  = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        predicted = route_message(it);
        expected_results.push_back(typed ? want : predicted);
        n_sent++;
        @(negedge clk);
    endtask

    task automatic wait_for_quiet();
        in_valid = 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_source(input logic idx, input logic [SRC_W-1:0] value);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == CFG_IR_SOURCE)
            ir_src = value;
        else
            pwr_src = value;
    endtask

    // result checker
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            got = '{status_t'(status), event_t'(event_kind), out_module_id, out_len,
                    {out_w6, out_w5, out_w4, out_w3, out_w2, out_w1, out_w0}};
            if (n_checked % 40 == 0)
                recv_fast = ($urandom_range(0, 2) == 0);
            stall_left = recv_fast ? 0 : $urandom_range(0, MAX_WAIT);
            n_checked++;
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%t: result with nothing expected: status %0d kind %0d id %0d",
                             $realtime, got.status, got.kind, got.module_id);
            end
            else
            begin
                want = expected_results.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                    begin
                        $display("%t: mismatch on result %0d", $realtime, n_checked);
                        $display("  expected status %0d kind %0d id %0d len %0d words %h",
                                 want.status, want.kind, want.module_id, want.len, want.body);
                        $display("  actual   status %0d kind %0d id %0d len %0d words %h",
                                 got.status, got.kind, got.module_id, got.len, got.body);
                    end
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else
            out_stall <= 1'b0;
    end

    initial
    begin
        int ir_cfg  [NUM_PHASES];
        int pwr_cfg [NUM_PHASES];
        int deliver_pct;

        ir_cfg    = '{3, 32767, 0, 6, 0};
        pwr_cfg   = '{5, 0, 32767, 6, 0};
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        op        = OP_DELIVER;
        module_id = '0;
        msg_len   = '0;
        {body_w0, body_w1, body_w2, body_w3, body_w4, body_w5, body_w6} = '0;
        cfg_we    = 1'b0;
        cfg_index = CFG_IR_SOURCE;
        cfg_data  = '0;
        ir_src    = SRC_W'(3);
        pwr_src   = SRC_W'(5);
        wake_armed = 1'b0;
        for (int m = 0; m < NUM_MODULES; m++)
        begin
            wr_slot[m] = 0;
            rd_slot[m] = 0;
            fill[m]    = 0;
        end
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed, under the reset source ids
        directed.push_back('{stim(OP_READ, 1, 0, 0, 0), 1'b1, res(ST_EMPTY, EV_NONE, 1, 0, 0)});
        directed.push_back('{stim(OP_DELIVER, 0, 8, 1, 2), 1'b1, res(ST_BAD, EV_NONE, 0, 0, 0)});
        directed.push_back('{stim(OP_DELIVER, NUM_MODULES + 1, 8, 1, 2), 1'b1,
                             res(ST_BAD, EV_NONE, NUM_MODULES + 1, 0, 0)});
        directed.push_back('{stim(OP_DELIVER, -32768, 4, 0, 0), 1'b1,
                             res(ST_BAD, EV_NONE, -32768, 0, 0)});
        directed.push_back('{stim(OP_DELIVER, 32767, 4, 0, 0), 1'b1,
                             res(ST_BAD, EV_NONE, 32767, 0, 0)});
        directed.push_back('{stim(OP_READ, -1, 0, 0, 0), 1'b1, res(ST_BAD, EV_NONE, -1, 0, 0)});
        // negative id whose low bits equal the ir source
        directed.push_back('{stim(OP_DELIVER, 16'sh8003, 4, 7, 0), 1'b1,
                             res(ST_BAD, EV_NONE, 16'sh8003, 0, 0)});
        directed.push_back('{stim(OP_DELIVER, 3, 4, 32'hffff_ffff, 32'h5a5a_5a5a), 1'b1,
                             res(ST_OK, EV_IR, 3, 4, 32'hffff_ffff)});
        directed.push_back('{stim(OP_DELIVER, 3, 5, 32'h1234_5678, 32'h9abc_def0), 1'b0, '0});
        directed.push_back('{stim(OP_DELIVER, 5, 4, 0, 0), 1'b1, res(ST_OK, EV_NONE, 5, 0, 0)});
        directed.push_back('{stim(OP_ARM, 9, 4, 0, 0), 1'b1, res(ST_OK, EV_NONE, 0, 0, 0)});
        directed.push_back('{stim(OP_ARM, 5, 4, 0, 0), 1'b1, res(ST_OK, EV_NONE, 0, 0, 0)});
        directed.push_back('{stim(OP_DELIVER, 5, 4, 0, 32'hffff_ffff), 1'b1,
                             res(ST_OK, EV_TIMER, 5, 0, 0)});
        directed.push_back('{stim(OP_DELIVER, 5, 4, 0, 0), 1'b1, res(ST_OK, EV_NONE, 5, 0, 0)});
        directed.push_back('{stim(OP_DELIVER, 5, 4, 1, 32'h0f0f_0f0f), 1'b0, '0});
        directed.push_back('{stim(OP_DELIVER, NUM_MODULES, -32768, 32'hffff_ffff, 32'hffff_ffff),
                             1'b0, '0});
        directed.push_back('{stim(OP_DELIVER, 1, 32767, 0, 0), 1'b0, '0});
        directed.push_back('{stim(OP_READ, NUM_MODULES, 0, 0, 0), 1'b0, '0});
        directed.push_back('{stim(OP_READ, 1, 0, 0, 0), 1'b0, '0});
        directed.push_back('{stim(OP_READ, 3, 0, 0, 0), 1'b0, '0});
        directed.push_back('{stim(OP_READ, 5, 0, 0, 0), 1'b0, '0});
        directed.push_back('{stim(OP_UNUSED, 7, 9, 32'hdead_beef, 1), 1'b1, '0});
        directed.push_back('{stim(OP_READ, NUM_MODULES + 1, 0, 0, 0), 1'b1,
                             res(ST_BAD, EV_NONE, NUM_MODULES + 1, 0, 0)});
        foreach (directed[i])
            send_item(directed[i].stim, directed[i].typed, directed[i].want);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            if (p > 0)
            begin
                wait_for_quiet();
                if (p == NUM_PHASES - 1)
                begin
                    ir_cfg[p]  = $urandom_range(1, NUM_MODULES);
                    pwr_cfg[p] = $urandom_range(1, NUM_MODULES);
                end
                write_source(CFG_IR_SOURCE, SRC_W'(ir_cfg[p]));
                write_source(CFG_POWER_SOURCE, SRC_W'(pwr_cfg[p]));
            end
            // alternate between filling queues and draining them
            deliver_pct = (p % 2 == 0) ? 65 : 35;
            for (int n = 0; n < ITEMS_PER_RUN; n++)
            begin
                if (n == ITEMS_PER_RUN / 2)
                    wait_for_quiet();
                send_item(random_item(deliver_pct), 1'b0, '0);
            end
        end

        wait_for_quiet();
        repeat (8) @(negedge clk);
        $display("%0d transactions sent, %0d results checked: %0d queued, %0d read back, "
                 , n_sent, n_checked, n_queued, n_read);
        $display("%0d dropped on full queue, %0d ir keys, %0d wakeups, %0d bad ids, %0d empty",
                 n_full, n_ir, n_wake, n_bad, n_empty);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("mailbox_message_router_tb passed");
        else
            $display("mailbox_message_router_tb failed");
        $finish;
    end

endmodule
